// File: hdl/gelu_pkg.sv
// Package for the GELU activation unit: fixed-point constants, config register
// indexes and the elaboration-time helpers that build the interpolation tables.
// No dependencies.
`default_nettype none

package gelu_pkg;

    localparam logic CFG_USE_TANH_FORM = 1'b0;
    localparam logic CFG_BACKWARD_MODE = 1'b1;

    typedef enum logic [1:0] {
        t_TAB_TANH  = 2'd0,
        t_TAB_ERF   = 2'd1,
        t_TAB_GAUSS = 2'd2
    } t_tab_sel;

    localparam int unsigned FRAC_BITS      = 18;
    localparam logic [19:0] KAPPA_Q20      = 20'd46887;
    localparam logic [19:0] KAPPA3_Q20     = 20'd140661;
    localparam logic [19:0] BETA_Q20       = 20'd836643;
    localparam logic [19:0] RSQRT2_Q20     = 20'd741455;
    localparam logic [19:0] PDFK_Q20       = 20'd418321;
    localparam logic [63:0] TWO_RSQRTPI_Q30 = 64'd1211587905;
    localparam logic [63:0] ONE_Q30        = 64'd1073741824;

    // (a*b) >> sh with round half up over the full product
    function automatic logic [63:0] mul_shr(input logic [63:0] a, input logic [63:0] b,
                                            input int unsigned sh);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p + (128'd1 << (sh - 1));
        return 64'(p >> sh);
    endfunction

    // restoring long division, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-a), Q30 in and out
    function automatic logic [63:0] exp_neg(input logic [63:0] a);
        logic [63:0]        b;
        logic [63:0]        term;
        logic signed [64:0] sum;
        logic [63:0]        v;
        b    = a >> 5;
        term = ONE_Q30;
        sum  = 65'(ONE_Q30);
        for (int k = 1; k <= 16; k++) begin
            term = udiv64(mul_shr(term, b, 30), 64'(k));
            if (k % 2 == 1) begin
                sum = sum - 65'(term);
            end else begin
                sum = sum + 65'(term);
            end
        end
        v = sum[64] ? 64'd0 : sum[63:0];
        for (int i = 0; i < 5; i++) begin
            v = mul_shr(v, v, 30);
        end
        return (v > ONE_Q30) ? ONE_Q30 : v;
    endfunction

    function automatic logic [15:0] to_q15(input logic [63:0] v);
        logic [63:0] r;
        r = (v + 64'd16384) >> 15;
        return (r > 64'd32768) ? 16'd32768 : r[15:0];
    endfunction

endpackage

`default_nettype wire

// File: hdl/gelu_activation_unit.sv
// Elementwise GELU unit, forward activation and input gradient, tanh or erf form.
// Depends on gelu_pkg for constants and table construction helpers.
//
// The rate is one word per cycle while the output is not stalled, set by the 17-stage
// pipeline that splits the wide multiplies, the table lookups and the rounding adds into
// stages of about equal depth. Bubbles close up under output stall, so the input is
// stalled only when all stages are full. Tables of tanh, erf and the Gaussian are built
// at elaboration and read as constant logic.
// Write the configuration only while the pipeline is empty.
`default_nettype none

module gelu_activation_unit
    import gelu_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire               i_cfg_idx,
    input  wire               i_cfg_data,
    input  wire               i_in_valid,
    output logic              o_in_stall,
    input  wire signed [15:0] i_x_sample,
    input  wire signed [15:0] i_grad_in,
    output logic              o_out_valid,
    input  wire               i_out_stall,
    output logic signed [15:0] o_y_value,
    output logic              o_saturated
);

    localparam int NS = 17;
    localparam int IW = $clog2(TABLE_ENTRIES + 1);
    localparam int PW = FRAC_BITS + IW;

    typedef logic [15:0] t_tab [0:TABLE_ENTRIES];

    function automatic t_tab build_tab(input t_tab_sel sel);
        t_tab        tab;
        logic [63:0] acc;
        logic [63:0] fprev;
        logic [63:0] tq;
        logic [63:0] e;
        logic [63:0] um;
        logic [63:0] fm;
        logic [63:0] fe;
        acc   = '0;
        fprev = ONE_Q30;
        for (int k = 0; k <= TABLE_ENTRIES; k++) begin
            tq = udiv64(64'(k) << 32, 64'(TABLE_ENTRIES));
            unique case (sel)
                t_TAB_TANH: begin
                    e = exp_neg(tq << 1);
                    tab[k] = to_q15(udiv64((ONE_Q30 - e) << 30, ONE_Q30 + e));
                end
                t_TAB_GAUSS: begin
                    tab[k] = to_q15(exp_neg(mul_shr(tq, tq, 31)));
                end
                default: begin
                    if (k > 0) begin
                        um = udiv64(64'(2 * k - 1) << 31, 64'(TABLE_ENTRIES));
                        fm = exp_neg(mul_shr(um, um, 30));
                        fe = exp_neg(mul_shr(tq, tq, 30));
                        acc = acc + fprev + (fm << 2) + fe;
                        fprev = fe;
                    end
                    tab[k] = to_q15(mul_shr(udiv64(acc << 1, 64'(3 * TABLE_ENTRIES)),
                                            TWO_RSQRTPI_Q30, 30));
                end
            endcase
        end
        return tab;
    endfunction

    localparam t_tab TAB_TANH  = build_tab(t_TAB_TANH);
    localparam t_tab TAB_ERF   = build_tab(t_TAB_ERF);
    localparam t_tab TAB_GAUSS = build_tab(t_TAB_GAUSS);

    logic r_use_tanh;
    logic r_bwd;

    logic [NS:1] r_vld;
    logic [NS:1] w_adv;

    logic [16:0] r_a   [1:15];
    logic [16:0] r_d   [1:15];
    logic        r_xn  [1:15];
    logic        r_dn  [1:15];
    logic [18:0] r_ea  [1:5];
    logic [43:0] r_dq  [4:12];
    logic        r_big_a [6:9];
    logic        r_big_b [6:9];
    logic [17:0] r_fr_a  [7:8];
    logic [17:0] r_fr_b  [7:8];
    logic [16:0] r_onep  [11:15];
    logic [51:0] r_pk    [12:14];

    logic [30:0] r_aa;
    logic [45:0] r_a3;
    logic [47:0] r_ds;
    logic [61:0] r_k3;
    logic [67:0] r_dsb;
    logic [61:0] r_s;
    logic [50:0] r_ph, r_pl;
    logic [17:0] r_arg_a, r_arg_b;
    logic [IW-1:0] r_idx_a, r_idx_b;
    logic [15:0] r_t0a, r_t1a, r_t0b, r_t1b;
    logic [34:0] r_m0a, r_m1a, r_m0b, r_m1b;
    logic [15:0] r_f, r_g;
    logic [30:0] r_thth;
    logic [32:0] r_ag;
    logic [45:0] r_at2;
    logic [67:0] r_rh, r_rl;
    logic [44:0] r_r;
    logic [52:0] r_sm;
    logic        r_sneg;
    logic [69:0] r_prod;
    logic        r_neg;
    logic [15:0] r_y;
    logic        r_sat;

    logic [16:0] n_a, n_d;
    logic [30:0] n_aa;
    logic [18:0] n_ea;
    logic [45:0] n_a3;
    logic [47:0] n_ds;
    logic [61:0] n_k3;
    logic [67:0] n_dsb;
    logic [61:0] n_s;
    logic [43:0] n_dq;
    logic [50:0] n_ph, n_pl;
    logic [81:0] w_tsum;
    logic [17:0] n_arg_a, n_arg_b;
    logic        n_big_a, n_big_b;
    logic [PW-1:0] w_pa, w_pb;
    logic [15:0] n_t0a, n_t1a, n_t0b, n_t1b;
    logic [34:0] n_m0a, n_m1a, n_m0b, n_m1b;
    logic [35:0] w_suma, w_sumb;
    logic [15:0] n_f, n_g;
    logic [16:0] n_onep;
    logic [30:0] n_thth;
    logic [32:0] n_ag;
    logic [45:0] n_at2;
    logic [51:0] n_pk;
    logic [67:0] n_rh, n_rl;
    logic [89:0] w_rsum;
    logic [44:0] n_r;
    logic [53:0] w_base, w_add, w_ssum;
    logic [52:0] n_sm;
    logic        n_sneg;
    logic [52:0] w_opa;
    logic [16:0] w_opb;
    logic [69:0] n_prod;
    logic        n_neg;
    logic [70:0] w_rnd;
    logic [54:0] w_mag;
    logic [15:0] w_magc;
    logic [15:0] n_y;
    logic        n_sat;

    always_comb begin
        w_adv[NS] = !r_vld[NS] || !i_out_stall;
        for (int k = NS - 1; k >= 1; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign o_in_stall  = !w_adv[1];
    assign o_out_valid = r_vld[NS];
    assign o_y_value   = r_y;
    assign o_saturated = r_sat;

    always_comb begin
        n_a  = i_x_sample[15] ? 17'h10000 - {1'b0, i_x_sample} : {1'b0, i_x_sample};
        n_d  = i_grad_in[15] ? 17'h10000 - {1'b0, i_grad_in} : {1'b0, i_grad_in};
        n_aa = 31'(34'(n_a) * 34'(n_a));
        n_ea = 19'((37'(n_a) * 37'(RSQRT2_Q20) + 37'd32768) >> 16);

        n_a3 = 46'(48'(r_aa) * 48'(r_a[1]));
        n_ds = (48'd1 << 44) + 48'(48'(r_aa) * 48'(KAPPA3_Q20));

        n_k3  = 62'(r_a3) * 62'(KAPPA_Q20);
        n_dsb = 68'(r_ds) * 68'(BETA_Q20);

        n_s  = (62'(r_a[3]) << 44) + r_k3;
        n_dq = 44'((r_dsb + (68'd1 << 23)) >> 24);

        n_ph = 51'(r_s[61:31]) * 51'(BETA_Q20);
        n_pl = 51'(r_s[30:0]) * 51'(BETA_Q20);

        w_tsum  = {r_ph, 31'd0} + 82'(r_pl) + (82'd1 << 59);
        n_arg_a = r_use_tanh ? w_tsum[77:60] : r_ea[5][17:0];
        n_big_a = r_use_tanh ? (w_tsum[81:78] != 4'd0) : r_ea[5][18];
        n_arg_b = {r_a[5][13:0], 4'd0};
        n_big_b = (r_a[5][16:14] != 3'd0);

        w_pa = PW'(r_arg_a) * PW'(TABLE_ENTRIES);
        w_pb = PW'(r_arg_b) * PW'(TABLE_ENTRIES);

        n_t0a = r_use_tanh ? TAB_TANH[r_idx_a] : TAB_ERF[r_idx_a];
        n_t1a = r_use_tanh ? TAB_TANH[r_idx_a + IW'(1)] : TAB_ERF[r_idx_a + IW'(1)];
        n_t0b = TAB_GAUSS[r_idx_b];
        n_t1b = TAB_GAUSS[r_idx_b + IW'(1)];

        n_m0a = 35'(r_t0a) * ((35'd1 << FRAC_BITS) - 35'(r_fr_a[8]));
        n_m1a = 35'(r_t1a) * 35'(r_fr_a[8]);
        n_m0b = 35'(r_t0b) * ((35'd1 << FRAC_BITS) - 35'(r_fr_b[8]));
        n_m1b = 35'(r_t1b) * 35'(r_fr_b[8]);

        w_suma = 36'(r_m0a) + 36'(r_m1a) + (36'd1 << (FRAC_BITS - 1));
        w_sumb = 36'(r_m0b) + 36'(r_m1b) + (36'd1 << (FRAC_BITS - 1));
        n_f    = r_big_a[9] ? 16'd32768 : w_suma[33:18];
        n_g    = r_big_b[9] ? 16'd0 : w_sumb[33:18];

        n_onep = r_xn[10] ? 17'd32768 - 17'(r_f) : 17'd32768 + 17'(r_f);
        n_thth = 31'(32'(r_f) * 32'(r_f));
        n_ag   = 33'(r_a[10]) * 33'(r_g);

        n_at2 = 46'(48'(r_a[11]) * 48'(31'h4000_0000 - r_thth));
        n_pk  = 52'(r_ag) * 52'(PDFK_Q20);

        n_rh = 68'(r_at2) * 68'(r_dq[12][43:22]);
        n_rl = 68'(r_at2) * 68'(r_dq[12][21:0]);

        w_rsum = {r_rh, 22'd0} + 90'(r_rl) + (90'd1 << 44);
        n_r    = w_rsum[89:45];

        w_base = r_use_tanh ? 54'({r_onep[14], 22'd0}) : 54'({r_onep[14], 31'd0});
        w_add  = r_use_tanh ? 54'(r_r) : 54'(r_pk[14]);
        w_ssum = r_xn[14] ? w_base - w_add : w_base + w_add;
        n_sneg = w_ssum[53];
        n_sm   = n_sneg ? 53'(54'd0 - w_ssum) : w_ssum[52:0];

        w_opa  = r_bwd ? r_sm : 53'(r_a[15]);
        w_opb  = r_bwd ? r_d[15] : r_onep[15];
        n_prod = 70'(w_opa) * 70'(w_opb);
        n_neg  = r_bwd ? (r_sneg ^ r_dn[15]) : r_xn[15];

        if (!r_bwd) begin
            w_rnd = 71'(r_prod) + (71'd1 << 15);
            w_mag = 55'(w_rnd >> 16);
        end else if (r_use_tanh) begin
            w_rnd = 71'(r_prod) + (71'd1 << 37);
            w_mag = 55'(w_rnd >> 38);
        end else begin
            w_rnd = 71'(r_prod) + (71'd1 << 46);
            w_mag = 55'(w_rnd >> 47);
        end
        if (r_neg) begin
            n_sat  = (w_mag > 55'd32768);
            w_magc = n_sat ? 16'd32768 : w_mag[15:0];
            n_y    = 16'd0 - w_magc;
        end else begin
            n_sat  = (w_mag > 55'd32767);
            w_magc = n_sat ? 16'd32767 : w_mag[15:0];
            n_y    = w_magc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_tanh <= 1'b0;
            r_bwd      <= 1'b0;
            r_vld      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_USE_TANH_FORM: r_use_tanh <= i_cfg_data;
                    CFG_BACKWARD_MODE: r_bwd      <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_adv[1]) begin
                r_vld[1] <= i_in_valid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_a[1]  <= n_a;
            r_d[1]  <= n_d;
            r_xn[1] <= i_x_sample[15];
            r_dn[1] <= i_grad_in[15];
            r_ea[1] <= n_ea;
            r_aa    <= n_aa;
        end
        for (int k = 2; k <= 15; k++) begin
            if (w_adv[k]) begin
                r_a[k]  <= r_a[k-1];
                r_d[k]  <= r_d[k-1];
                r_xn[k] <= r_xn[k-1];
                r_dn[k] <= r_dn[k-1];
            end
        end
        for (int k = 2; k <= 5; k++) begin
            if (w_adv[k]) begin
                r_ea[k] <= r_ea[k-1];
            end
        end
        if (w_adv[2]) begin
            r_a3 <= n_a3;
            r_ds <= n_ds;
        end
        if (w_adv[3]) begin
            r_k3  <= n_k3;
            r_dsb <= n_dsb;
        end
        if (w_adv[4]) begin
            r_s     <= n_s;
            r_dq[4] <= n_dq;
        end
        for (int k = 5; k <= 12; k++) begin
            if (w_adv[k]) begin
                r_dq[k] <= r_dq[k-1];
            end
        end
        if (w_adv[5]) begin
            r_ph <= n_ph;
            r_pl <= n_pl;
        end
        if (w_adv[6]) begin
            r_arg_a    <= n_arg_a;
            r_arg_b    <= n_arg_b;
            r_big_a[6] <= n_big_a;
            r_big_b[6] <= n_big_b;
        end
        for (int k = 7; k <= 9; k++) begin
            if (w_adv[k]) begin
                r_big_a[k] <= r_big_a[k-1];
                r_big_b[k] <= r_big_b[k-1];
            end
        end
        if (w_adv[7]) begin
            r_idx_a   <= w_pa[PW-1:FRAC_BITS];
            r_idx_b   <= w_pb[PW-1:FRAC_BITS];
            r_fr_a[7] <= w_pa[FRAC_BITS-1:0];
            r_fr_b[7] <= w_pb[FRAC_BITS-1:0];
        end
        if (w_adv[8]) begin
            r_fr_a[8] <= r_fr_a[7];
            r_fr_b[8] <= r_fr_b[7];
            r_t0a     <= n_t0a;
            r_t1a     <= n_t1a;
            r_t0b     <= n_t0b;
            r_t1b     <= n_t1b;
        end
        if (w_adv[9]) begin
            r_m0a <= n_m0a;
            r_m1a <= n_m1a;
            r_m0b <= n_m0b;
            r_m1b <= n_m1b;
        end
        if (w_adv[10]) begin
            r_f <= n_f;
            r_g <= n_g;
        end
        if (w_adv[11]) begin
            r_onep[11] <= n_onep;
            r_thth     <= n_thth;
            r_ag       <= n_ag;
        end
        for (int k = 12; k <= 15; k++) begin
            if (w_adv[k]) begin
                r_onep[k] <= r_onep[k-1];
            end
        end
        if (w_adv[12]) begin
            r_at2     <= n_at2;
            r_pk[12]  <= n_pk;
        end
        for (int k = 13; k <= 14; k++) begin
            if (w_adv[k]) begin
                r_pk[k] <= r_pk[k-1];
            end
        end
        if (w_adv[13]) begin
            r_rh <= n_rh;
            r_rl <= n_rl;
        end
        if (w_adv[14]) begin
            r_r <= n_r;
        end
        if (w_adv[15]) begin
            r_sm   <= n_sm;
            r_sneg <= n_sneg;
        end
        if (w_adv[16]) begin
            r_prod <= n_prod;
            r_neg  <= n_neg;
        end
        if (w_adv[NS]) begin
            r_y   <= n_y;
            r_sat <= n_sat;
        end
    end

    a_sat_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_saturated |-> (r_y == 16'h7fff || r_y == 16'h8000))
        else $error("saturated word not at a range limit");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> ($countones(r_vld) == NS && i_out_stall))
        else $error("input stalled with a free stage");

    a_hold_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] && !w_adv[1] |=> r_vld[1] && $stable(r_a[1]))
        else $error("held word lost in first stage");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NS-1] && !i_out_stall |=> r_vld[NS])
        else $error("word dropped before output");

endmodule

`default_nettype wire
